[rtl/pps_pkg.sv]
package pps_pkg;

  localparam int PPS_SLOTS = 16;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [2:0] STAT_LOADED   = 3'd0;
  localparam logic [2:0] STAT_FULL     = 3'd1;
  localparam logic [2:0] STAT_IDLE     = 3'd2;
  localparam logic [2:0] STAT_RAN      = 3'd3;
  localparam logic [2:0] STAT_COMPLETE = 3'd4;

  typedef struct packed {
    logic        kind;
    logic [15:0] process_id;
    logic [31:0] arrival_time;
    logic [15:0] burst_length;
    logic [7:0]  priority_level;
  } sched_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [15:0] running_id;
    logic [31:0] now_time;
    logic        switched;
    logic [31:0] first_start;
    logic [31:0] turnaround;
    logic [31:0] waiting;
  } sched_out_t;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] arrival;
    logic [15:0] burst;
    logic [15:0] remaining;
    logic [7:0]  prio;
    logic [31:0] start_time;
  } slot_rec_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_LOAD,
    S_SCAN,
    S_DRAIN,
    S_APPLY,
    S_CALC,
    S_DONE
  } pps_state_t;

  typedef struct packed {
    logic capture;
    logic step;
    logic scan;
    logic ld_store;
    logic ld_fail;
    logic apply;
    logic calc;
    logic publish;
  } pps_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic burst_zero;
    logic slot_free;
    logic scan_last;
    logic out_busy;
  } pps_stat_t;

endpackage

[rtl/pps_ctrl.sv]
module pps_ctrl
  import pps_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  pps_stat_t st,
  output pps_cmd_t  cmd
);

  pps_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        if (st.is_tick) begin
          state_nxt = S_SCAN;
        end else if (st.burst_zero) begin
          cmd.ld_fail = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        if (st.slot_free) begin
          cmd.ld_store = 1'b1;
          state_nxt    = S_DONE;
        end else if (st.scan_last) begin
          cmd.ld_fail = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        cmd.scan = 1'b1;
        if (st.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = S_CALC;
      end
      S_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!st.out_busy) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/pps_datapath.sv]
module pps_datapath
  import pps_pkg::*;
#(
  parameter int SLOTS = PPS_SLOTS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  sched_in_t  in_data,
  input  pps_cmd_t   cmd,
  output pps_stat_t  st,
  output logic       out_valid,
  input  logic       out_ready,
  output sched_out_t out_data,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  sched_in_t         in_r;
  logic              use_prio_r;
  logic [31:0]       clock_r;
  logic [SLOTS-1:0]  valid_r;
  logic [SLOTS-1:0]  started_r;
  slot_rec_t         mem [SLOTS];
  slot_rec_t         rd_r;
  logic              rd_v_r;
  logic [SW-1:0]     rd_idx_r;
  logic [SW-1:0]     idx_r;
  logic              have_r;
  logic [71:0]       best_key_r;
  logic [SW-1:0]     best_slot_r;
  logic [7:0]        best_prio_r;
  logic [15:0]       best_burst_r;
  logic [31:0]       best_start_r;
  logic              best_started_r;
  logic [SW-1:0]     cur_slot_r;
  logic              cur_valid_r;
  sched_out_t        res_r;
  sched_out_t        out_r;
  logic              out_valid_r;

  logic [71:0]       cand_key;
  logic              cand_elig;
  logic              cand_hit;
  logic [15:0]       best_rem;
  logic [31:0]       best_arr;
  logic [15:0]       best_id;
  logic [31:0]       clk_inc;
  logic [15:0]       rem_new;
  logic [31:0]       start_t;
  logic              done_now;
  logic              mem_we;
  logic [SW-1:0]     mem_waddr;
  slot_rec_t         mem_wdata;
  logic [SW+3:0]     idx_ext;
  logic [SW+3:0]     best_ext;
  sched_out_t        res_init;

  assign idx_ext  = {4'b0000, idx_r};
  assign best_ext = {4'b0000, best_slot_r};

  assign best_rem = best_key_r[63:48];
  assign best_arr = best_key_r[47:16];
  assign best_id  = best_key_r[15:0];

  assign cand_key  = {(use_prio_r ? rd_r.prio : 8'd0), rd_r.remaining, rd_r.arrival, rd_r.id};
  assign cand_elig = valid_r[rd_idx_r] && (rd_r.remaining != 16'd0) &&
                     (rd_r.arrival <= clock_r);
  assign cand_hit  = rd_v_r && cand_elig && (!have_r || (cand_key < best_key_r));

  assign clk_inc  = (clock_r == 32'hFFFF_FFFF) ? clock_r : clock_r + 32'd1;
  assign rem_new  = best_rem - 16'd1;
  assign start_t  = best_started_r ? best_start_r : clock_r;
  assign done_now = (rem_new == 16'd0);

  always_comb begin
    res_init          = '0;
    res_init.now_time = clock_r;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = '0;
    if (cmd.ld_store) begin
      mem_we               = 1'b1;
      mem_wdata.id         = in_r.process_id;
      mem_wdata.arrival    = in_r.arrival_time;
      mem_wdata.burst      = in_r.burst_length;
      mem_wdata.remaining  = in_r.burst_length;
      mem_wdata.prio       = in_r.priority_level;
      mem_wdata.start_time = 32'd0;
    end else if (cmd.apply && have_r) begin
      mem_we               = 1'b1;
      mem_waddr            = best_slot_r;
      mem_wdata.id         = best_id;
      mem_wdata.arrival    = best_arr;
      mem_wdata.burst      = best_burst_r;
      mem_wdata.remaining  = rem_new;
      mem_wdata.prio       = best_prio_r;
      mem_wdata.start_time = start_t;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_r     <= mem[idx_r];
    rd_idx_r <= idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_prio_r  <= 1'b1;
      clock_r     <= '0;
      valid_r     <= '0;
      started_r   <= '0;
      rd_v_r      <= 1'b0;
      have_r      <= 1'b0;
      cur_slot_r  <= '0;
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        use_prio_r <= cfg_wr_data;
      end
      rd_v_r <= cmd.scan;
      if (cmd.capture) begin
        have_r <= 1'b0;
      end else if (cand_hit) begin
        have_r <= 1'b1;
      end
      if (cmd.ld_store) begin
        valid_r[idx_r]   <= 1'b1;
        started_r[idx_r] <= 1'b0;
      end
      if (cmd.apply) begin
        clock_r <= clk_inc;
        if (have_r) begin
          cur_slot_r <= best_slot_r;
          if (done_now) begin
            valid_r[best_slot_r]   <= 1'b0;
            started_r[best_slot_r] <= 1'b0;
            cur_valid_r            <= 1'b0;
          end else begin
            started_r[best_slot_r] <= 1'b1;
            cur_valid_r            <= 1'b1;
          end
        end
      end
      if (cmd.publish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_r  <= in_data;
      idx_r <= '0;
      res_r <= res_init;
    end else if (cmd.step) begin
      idx_r <= idx_r + 1'b1;
    end
    if (cand_hit) begin
      best_key_r     <= cand_key;
      best_slot_r    <= rd_idx_r;
      best_prio_r    <= rd_r.prio;
      best_burst_r   <= rd_r.burst;
      best_start_r   <= rd_r.start_time;
      best_started_r <= started_r[rd_idx_r];
    end
    if (cmd.ld_store) begin
      res_r.status <= STAT_LOADED;
      res_r.slot   <= idx_ext[3:0];
    end
    if (cmd.ld_fail) begin
      res_r.status <= STAT_FULL;
    end
    if (cmd.apply) begin
      res_r.now_time <= clk_inc;
      if (have_r) begin
        res_r.status     <= done_now ? STAT_COMPLETE : STAT_RAN;
        res_r.slot       <= best_ext[3:0];
        res_r.running_id <= best_id;
        res_r.switched   <= !cur_valid_r || (cur_slot_r != best_slot_r);
        if (done_now) begin
          res_r.first_start <= start_t;
          res_r.turnaround  <= clk_inc - best_arr;
        end
      end else begin
        res_r.status <= STAT_IDLE;
      end
    end
    if (cmd.calc) begin
      if ((res_r.status == STAT_COMPLETE) &&
          (res_r.turnaround >= {16'd0, best_burst_r})) begin
        res_r.waiting <= res_r.turnaround - {16'd0, best_burst_r};
      end
    end
    if (cmd.publish) begin
      out_r <= res_r;
    end
  end

  assign st.is_tick    = (in_r.kind == KIND_TICK);
  assign st.burst_zero = (in_r.burst_length == 16'd0);
  assign st.slot_free  = !valid_r[idx_r];
  assign st.scan_last  = (idx_r == SW'(SLOTS - 1));
  assign st.out_busy   = out_valid_r && !out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  a_clock_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (clock_r == 32'hFFFF_FFFF) |=> (clock_r == 32'hFFFF_FFFF))
    else $error("saturated time moved");

  a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.apply && have_r && done_now) |=> !valid_r[$past(best_slot_r)])
    else $error("completed slot still valid");

  a_started_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ((started_r & ~valid_r) == '0))
    else $error("started flag on a free slot");

  a_wait_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.waiting <= out_r.turnaround))
    else $error("waiting exceeds turnaround");
`endif

endmodule

[rtl/preemptive_priority_srtf_scheduler.sv]
// Preemptive priority / shortest-remaining-time-first scheduler.
// Input channel (in_valid/in_ready/in_data): one beat is either a load, which
// stores a process into the lowest free slot, or a tick, which runs the best
// eligible process for one unit. Output channel (out_valid/out_ready/out_data)
// carries exactly one result beat per input beat, in order.
// cfg_wr_en/cfg_wr_data set the priority mode; write only while idle.
// A tick passes through decode, a scan of all slots, drain, apply, calc and
// publish; the scan reads one slot record a cycle from the slot memory and
// compares it with the running best. A load goes through decode, then steps
// past each occupied slot ahead of the first free one; a zero-burst load goes
// from decode to publish. One item is in work at a time; the next can be
// accepted in the cycle after the previous result is staged.
// The output register holds a result while the receiver stalls; the next item
// is accepted and worked on meanwhile, and waits to publish until it drains.
// Reset (rst_n low, synchronous) frees all slots, clears time to zero, drops
// any pending result and sets the priority mode to on.
module preemptive_priority_srtf_scheduler
  import pps_pkg::*;
#(
  parameter int SLOTS = PPS_SLOTS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  sched_in_t  in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output sched_out_t out_data,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data
);

  pps_cmd_t  cmd;
  pps_stat_t st;

  pps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  pps_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .cmd         (cmd),
    .st          (st),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

endmodule

[test/sched_checker.sv]
`timescale 1ns / 100ps

module sched_checker
  import pps_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  sched_in_t  in_data,
  input  logic       out_valid,
  input  logic       out_ready,
  input  sched_out_t out_data,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  output int         errors,
  output int         pending
);

  logic        prio_mode;
  logic        occupied [PPS_SLOTS];
  logic [15:0] p_id     [PPS_SLOTS];
  logic [31:0] p_arr    [PPS_SLOTS];
  logic [15:0] p_burst  [PPS_SLOTS];
  logic [15:0] p_left   [PPS_SLOTS];
  logic [7:0]  p_prio   [PPS_SLOTS];
  logic        begun    [PPS_SLOTS];
  logic [31:0] p_start  [PPS_SLOTS];
  logic [31:0] sim_clock;
  logic [3:0]  last_slot;
  logic        last_live;

  sched_out_t due_results [$];

  function automatic void reset_model();
    prio_mode = 1'b1;
    for (int i = 0; i < PPS_SLOTS; i++) begin
      occupied[i] = 1'b0;
      begun[i]    = 1'b0;
      p_id[i]     = '0;
      p_arr[i]    = '0;
      p_burst[i]  = '0;
      p_left[i]   = '0;
      p_prio[i]   = '0;
      p_start[i]  = '0;
    end
    sim_clock = '0;
    last_slot = '0;
    last_live = 1'b0;
  endfunction

  function automatic bit ahead_of(int a, int b);
    if (prio_mode && p_prio[a] != p_prio[b]) return p_prio[a] < p_prio[b];
    if (p_left[a] != p_left[b]) return p_left[a] < p_left[b];
    if (p_arr[a] != p_arr[b]) return p_arr[a] < p_arr[b];
    return p_id[a] < p_id[b];
  endfunction

  function automatic sched_out_t schedule_outcome(sched_in_t it);
    sched_out_t  r;
    int          pick;
    logic [31:0] span;
    r = '0;
    pick = -1;
    if (it.kind == KIND_LOAD) begin
      r.status = STAT_FULL;
      if (it.burst_length != 0) begin
        for (int i = 0; i < PPS_SLOTS; i++) begin
          if (!occupied[i] && pick < 0) pick = i;
        end
      end
      if (pick >= 0) begin
        occupied[pick] = 1'b1;
        p_id[pick]     = it.process_id;
        p_arr[pick]    = it.arrival_time;
        p_burst[pick]  = it.burst_length;
        p_left[pick]   = it.burst_length;
        p_prio[pick]   = it.priority_level;
        begun[pick]    = 1'b0;
        p_start[pick]  = '0;
        r.status = STAT_LOADED;
        r.slot   = 4'(pick);
      end
    end else begin
      for (int i = 0; i < PPS_SLOTS; i++) begin
        if (occupied[i] && p_left[i] != 0 && p_arr[i] <= sim_clock) begin
          if (pick < 0 || ahead_of(i, pick)) pick = i;
        end
      end
      if (pick < 0) begin
        r.status = STAT_IDLE;
        if (sim_clock != '1) sim_clock = sim_clock + 32'd1;
      end else begin
        r.switched = !last_live || last_slot != 4'(pick);
        if (!begun[pick]) begin
          begun[pick]   = 1'b1;
          p_start[pick] = sim_clock;
        end
        p_left[pick] = p_left[pick] - 16'd1;
        if (sim_clock != '1) sim_clock = sim_clock + 32'd1;
        r.slot       = 4'(pick);
        r.running_id = p_id[pick];
        last_slot    = 4'(pick);
        if (p_left[pick] == 0) begin
          r.status      = STAT_COMPLETE;
          r.first_start = p_start[pick];
          span          = sim_clock - p_arr[pick];
          r.turnaround  = span;
          r.waiting     = (span >= {16'd0, p_burst[pick]}) ? span - {16'd0, p_burst[pick]} : '0;
          occupied[pick] = 1'b0;
          begun[pick]    = 1'b0;
          last_live      = 1'b0;
        end else begin
          r.status  = STAT_RAN;
          last_live = 1'b1;
        end
      end
    end
    r.now_time = sim_clock;
    return r;
  endfunction

  function automatic int field_diff(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : watch
    sched_out_t want;
    sched_out_t fresh;
    int         bad;
    bad = 0;
    if (!rst_n) begin
      reset_model();
      due_results.delete();
    end else begin
      if (cfg_wr_en) prio_mode = cfg_wr_data;
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: beat with none expected, expected nothing actual %0h",
                   $time, out_data);
          bad++;
        end else begin
          want = due_results.pop_front();
          bad += field_diff("status", 32'(want.status), 32'(out_data.status));
          bad += field_diff("slot", 32'(want.slot), 32'(out_data.slot));
          bad += field_diff("running_id", 32'(want.running_id), 32'(out_data.running_id));
          bad += field_diff("now_time", want.now_time, out_data.now_time);
          bad += field_diff("switched", 32'(want.switched), 32'(out_data.switched));
          bad += field_diff("first_start", want.first_start, out_data.first_start);
          bad += field_diff("turnaround", want.turnaround, out_data.turnaround);
          bad += field_diff("waiting", want.waiting, out_data.waiting);
        end
      end
      if (in_valid && in_ready) begin
        fresh       = schedule_outcome(in_data);
        due_results = {due_results, fresh};
      end
    end
    errors  <= errors + bad;
    pending <= due_results.size();
  end

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import pps_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int PHASE_ITEMS = 170;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  sched_in_t  in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  sched_out_t out_data;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_wr_data = 1'b0;

  int          errors;
  int          pending;
  int          items_sent = 0;
  int unsigned ticks_sent = 0;
  int unsigned owed = 0;
  int          rx_count = 0;
  int unsigned rx_gap = 0;
  logic        rx_hold = 1'b0;
  int          idle_cycles = 0;

  preemptive_priority_srtf_scheduler u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  sched_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .errors      (errors),
    .pending     (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin : rx_side
    int unsigned gap;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_gap    <= 0;
    end else begin
      gap = rx_gap;
      if (out_valid && out_ready) begin
        rx_count <= rx_count + 1;
        gap = ((rx_count % 200) < 80) ? 0 : $urandom_range(0, 9);
      end else if (gap != 0) begin
        gap = gap - 1;
      end
      rx_gap    <= gap;
      out_ready <= (gap == 0) && !rx_hold;
    end
  end

  // hold the result channel long enough to back up the input
  initial begin
    wait (items_sent >= 300);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (400) @(posedge clk);
    rx_hold <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic send_item(input sched_in_t item);
    int unsigned gap;
    gap = ((items_sent % 200) < 50) ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (item.kind == KIND_TICK) begin
      ticks_sent++;
      if (owed != 0) owed--;
    end else if (item.burst_length != 0 && item.arrival_time <= ticks_sent + 64) begin
      owed += item.burst_length;
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_mode(input logic mode);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic sched_in_t make_load(logic [15:0] id, logic [31:0] arr,
                                          logic [15:0] burst, logic [7:0] prio);
    sched_in_t it;
    it.kind           = KIND_LOAD;
    it.process_id     = id;
    it.arrival_time   = arr;
    it.burst_length   = burst;
    it.priority_level = prio;
    return it;
  endfunction

  function automatic sched_in_t tick_item();
    sched_in_t it;
    it.kind           = KIND_TICK;
    it.process_id     = 16'($urandom);
    it.arrival_time   = $urandom;
    it.burst_length   = 16'($urandom);
    it.priority_level = 8'($urandom);
    return it;
  endfunction

  function automatic sched_in_t load_item();
    logic [15:0] id;
    logic [31:0] arr;
    logic [15:0] burst;
    logic [7:0]  prio;
    int unsigned pick;
    id = $urandom_range(0, 1) ? 16'($urandom_range(0, 3)) : 16'($urandom);
    pick = $urandom_range(0, 9);
    if (pick < 7) arr = 32'(ticks_sent + $urandom_range(0, 6));
    else if (pick < 9) arr = 32'($urandom_range(0, ticks_sent));
    else arr = 32'(ticks_sent + $urandom_range(7, 40));
    pick = $urandom_range(0, 99);
    if (pick < 2) burst = 16'd0;
    else if (pick < 77) burst = 16'($urandom_range(1, 5));
    else burst = 16'($urandom_range(6, 24));
    prio = ($urandom_range(0, 9) < 6) ? 8'($urandom_range(0, 3)) : 8'($urandom);
    return make_load(id, arr, burst, prio);
  endfunction

  function automatic sched_in_t noise_item();
    if ($urandom_range(0, 9) < 4) return tick_item();
    return make_load(16'($urandom), 32'(ticks_sent + $urandom_range(0, 3)),
                     16'($urandom_range(0, 3)), 8'($urandom));
  endfunction

  // a batch of loads, then ticks for part or all of the backlog; else a burst of mixed noise items
  task automatic run_episode();
    int          n;
    int unsigned span;
    if ($urandom_range(0, 99) < 15) begin
      n = $urandom_range(3, 20);
      repeat (n) send_item(noise_item());
    end else begin
      n = $urandom_range(1, 8);
      repeat (n) send_item(load_item());
      span = ($urandom_range(0, 4) == 0) ? owed / 2 : owed + $urandom_range(0, 4);
      repeat (span) send_item(tick_item());
    end
  endtask

  initial begin : stimulus
    logic mode_plan [5];
    int   start;
    mode_plan = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    set_mode(1'b1);

    send_item(tick_item());
    send_item(make_load(16'h1234, 32'd0, 16'd0, 8'd5));
    send_item(make_load(16'hFFFF, 32'd0, 16'd1, 8'hFF));
    send_item(make_load(16'h0000, 32'hFFFF_FFFF, 16'hFFFF, 8'h00));
    send_item(tick_item());
    for (int i = 0; i < 15; i++) begin
      send_item(make_load(16'(100 + i), 32'd2, 16'(i % 3 + 1), 8'(i % 3)));
    end
    send_item(make_load(16'h0200, 32'd2, 16'd1, 8'd0));
    repeat (4) send_item(tick_item());

    foreach (mode_plan[p]) begin
      settle();
      set_mode(mode_plan[p]);
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) run_episode();
    end

    settle();
    repeat (60) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/pps_pkg.sv
rtl/pps_ctrl.sv
rtl/pps_datapath.sv
rtl/preemptive_priority_srtf_scheduler.sv
test/sched_checker.sv
test/testbench.sv
